/* sv/brc_pkg.sv */
package brc_pkg;

   // sector size must stay a power of two: offsets and ranges use shifts
   localparam int unsigned SECTOR_BYTES = 512;
   localparam int unsigned SECTOR_SHIFT = $clog2(SECTOR_BYTES);
   localparam int unsigned ID_LENGTH    = 20;

   localparam logic [31:0] HDR_BYTES   = 32'd16;
   localparam logic [31:0] RANGE_BYTES = 32'd16;

   // request type codes from the header
   localparam logic [31:0] TYPE_READ    = 32'd0;
   localparam logic [31:0] TYPE_WRITE   = 32'd1;
   localparam logic [31:0] TYPE_FLUSH   = 32'd4;
   localparam logic [31:0] TYPE_GET_ID  = 32'd8;
   localparam logic [31:0] TYPE_DISCARD = 32'd11;

   // register indexes of the csr port
   localparam logic [1:0] CSR_CAPACITY     = 2'd0;
   localparam logic [1:0] CSR_READ_ONLY    = 2'd1;
   localparam logic [1:0] CSR_SERIAL       = 2'd2;
   localparam logic [1:0] CSR_DISCARD_EN   = 2'd3;

   typedef enum logic [2:0] {
      ACT_NOW     = 3'd0,
      ACT_READ    = 3'd1,
      ACT_WRITE   = 3'd2,
      ACT_FLUSH   = 3'd3,
      ACT_DISCARD = 3'd4,
      ACT_ID      = 3'd5
   } brc_action_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_IOERR  = 2'd1,
      ST_UNSUPP = 2'd2
   } brc_status_type;

   typedef struct packed {
      logic [10:0] out_count;
      logic [10:0] in_count;
      logic [31:0] header_len;
      logic [31:0] status_len;
      logic [31:0] req_type;
      logic [63:0] start_sector;
      logic [63:0] in_data_bytes;
      logic [63:0] out_data_bytes;
      logic [31:0] first_in_len;
      logic [31:0] second_out_len;
      logic [63:0] discard_sector;
      logic [31:0] discard_count;
   } brc_req_type;

   typedef struct packed {
      logic [63:0] capacity_bytes;
      logic        read_only;
      logic        serial_present;
      logic        discard_enabled;
   } brc_cfg_type;

   typedef struct packed {
      brc_action_type action;
      brc_status_type status;
      logic [31:0]    reported_len;
      logic [63:0]    byte_offset;
      logic [63:0]    xfer_len;
   } brc_rsp_type;

endpackage

/* sv/brc_decide.sv */
module brc_decide (
   input  brc_pkg::brc_req_type req,
   input  brc_pkg::brc_cfg_type cfg,
   output brc_pkg::brc_rsp_type rsp
);
   import brc_pkg::*;

   logic        has_status;
   logic        bad_layout;
   logic        is_discard;
   logic [63:0] sel_sector;
   logic [63:0] sel_len;
   logic [63:0] cap_sectors;
   logic [63:0] sel_offset;
   logic [63:0] room;
   logic        fits;
   logic [63:0] discard_len;
   logic [31:0] id_len;
   brc_rsp_type fail_io;
   brc_rsp_type fail_unsupp;

   assign has_status = (req.in_count != 11'd0) && (req.status_len != 32'd0);
   assign bad_layout = (req.out_count == 11'd0) || (req.in_count == 11'd0) ||
                       (req.status_len == 32'd0);

   // one shared range check: pick the sector and length by type
   assign is_discard  = (req.req_type == TYPE_DISCARD);
   assign discard_len = 64'(req.discard_count) << SECTOR_SHIFT;
   assign sel_sector  = is_discard ? req.discard_sector : req.start_sector;
   assign sel_len     = is_discard ? discard_len :
                        (req.req_type == TYPE_READ) ? req.in_data_bytes :
                        req.out_data_bytes;
   assign cap_sectors = cfg.capacity_bytes >> SECTOR_SHIFT;
   assign sel_offset  = sel_sector << SECTOR_SHIFT;
   // offset cannot exceed capacity once the sector check passes
   assign room        = cfg.capacity_bytes - sel_offset;
   assign fits        = (sel_sector <= cap_sectors) && (sel_len <= room);

   assign id_len = (req.first_in_len < 32'(ID_LENGTH)) ? req.first_in_len :
                   32'(ID_LENGTH);

   always_comb begin
      fail_io              = '0;
      fail_io.action       = ACT_NOW;
      fail_io.status       = ST_IOERR;
      fail_io.reported_len = {31'd0, has_status};
      fail_unsupp          = fail_io;
      fail_unsupp.status   = ST_UNSUPP;
   end

   always_comb begin
      rsp = fail_io;
      if (bad_layout) begin
         rsp = fail_io;
      end else if (req.header_len != HDR_BYTES) begin
         rsp = fail_unsupp;
      end else begin
         case (req.req_type)
            TYPE_READ: begin
               if (fits) begin
                  rsp.action       = ACT_READ;
                  rsp.status       = ST_OK;
                  rsp.reported_len = req.in_data_bytes[31:0] + 32'd1;
                  rsp.byte_offset  = sel_offset;
                  rsp.xfer_len     = req.in_data_bytes;
               end
            end
            TYPE_WRITE: begin
               if (!cfg.read_only && fits) begin
                  rsp.action       = ACT_WRITE;
                  rsp.status       = ST_OK;
                  rsp.reported_len = 32'd1;
                  rsp.byte_offset  = sel_offset;
                  rsp.xfer_len     = req.out_data_bytes;
               end
            end
            TYPE_FLUSH: begin
               rsp.action       = ACT_FLUSH;
               rsp.status       = ST_OK;
               rsp.reported_len = 32'd1;
               rsp.byte_offset  = '0;
               rsp.xfer_len     = '0;
            end
            TYPE_GET_ID: begin
               if (!cfg.serial_present || (req.in_count < 11'd2)) begin
                  rsp = fail_unsupp;
               end else begin
                  rsp.action       = ACT_ID;
                  rsp.status       = ST_OK;
                  rsp.reported_len = id_len + 32'd1;
                  rsp.byte_offset  = '0;
                  rsp.xfer_len     = 64'(id_len);
               end
            end
            TYPE_DISCARD: begin
               if (!cfg.discard_enabled || (req.out_count < 11'd2) ||
                   (req.second_out_len < RANGE_BYTES)) begin
                  rsp = fail_unsupp;
               end else if (fits) begin
                  rsp.action       = ACT_DISCARD;
                  rsp.status       = ST_OK;
                  rsp.reported_len = 32'd1;
                  rsp.byte_offset  = sel_offset;
                  rsp.xfer_len     = discard_len;
               end
            end
            default: begin
               rsp = fail_unsupp;
            end
         endcase
      end
   end

endmodule

/* sv/block_request_checker.sv */
// the request passes the input register, then the result register, and the
//    result strobe is high while the result register holds the result
// throughput: one transaction per cycle, every cycle; busy is high only in reset
// the result receiver cannot stall, so nothing ever backs up
// reset is synchronous and active high: clears the valid bits and the
//    configuration registers; payload registers are not reset
module block_request_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [10:0] req_out_count,
   input  logic [10:0] req_in_count,
   input  logic [31:0] req_header_len,
   input  logic [31:0] req_status_len,
   input  logic [31:0] req_req_type,
   input  logic [63:0] req_start_sector,
   input  logic [63:0] req_in_data_bytes,
   input  logic [63:0] req_out_data_bytes,
   input  logic [31:0] req_first_in_len,
   input  logic [31:0] req_second_out_len,
   input  logic [63:0] req_discard_sector,
   input  logic [31:0] req_discard_count,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_action,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_reported_len,
   output logic [63:0] rsp_byte_offset,
   output logic [63:0] rsp_xfer_len,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);
   import brc_pkg::*;

   // configuration registers
   brc_cfg_type cfg_ff;
   brc_cfg_type cfg_in;

   // input stage: request summary captured as it is accepted
   brc_req_type req_ff;
   brc_req_type req_in;
   logic        req_valid_ff;
   logic        req_valid_in;

   // result stage
   brc_rsp_type rsp_ff;
   brc_rsp_type rsp_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;

   logic        accept;

   // no internal backpressure: only reset keeps transactions out
   assign busy   = reset;
   assign accept = start && !busy;

   // csr writes, masked to register widths; spare indexes never appear
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_CAPACITY:   cfg_in.capacity_bytes  = csr_wdata;
            CSR_READ_ONLY:  cfg_in.read_only       = csr_wdata[0];
            CSR_SERIAL:     cfg_in.serial_present  = csr_wdata[0];
            CSR_DISCARD_EN: cfg_in.discard_enabled = csr_wdata[0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      req_in                = req_ff;
      req_valid_in          = accept;
      if (accept) begin
         req_in.out_count      = req_out_count;
         req_in.in_count       = req_in_count;
         req_in.header_len     = req_header_len;
         req_in.status_len     = req_status_len;
         req_in.req_type       = req_req_type;
         req_in.start_sector   = req_start_sector;
         req_in.in_data_bytes  = req_in_data_bytes;
         req_in.out_data_bytes = req_out_data_bytes;
         req_in.first_in_len   = req_first_in_len;
         req_in.second_out_len = req_second_out_len;
         req_in.discard_sector = req_discard_sector;
         req_in.discard_count  = req_discard_count;
      end
   end

   // layout, type and range decisions, all in one pass
   brc_decide u_decide (
      .req (req_ff),
      .cfg (cfg_ff),
      .rsp (rsp_in)
   );

   assign rsp_valid_in = req_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '0;
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   // result shows for exactly one cycle per transaction
   assign rsp_strobe       = rsp_valid_ff;
   assign rsp_action       = rsp_ff.action;
   assign rsp_status       = rsp_ff.status;
   assign rsp_reported_len = rsp_ff.reported_len;
   assign rsp_byte_offset  = rsp_ff.byte_offset;
   assign rsp_xfer_len     = rsp_ff.xfer_len;

endmodule

/* sv/brc_checker.sv */
module brc_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic [2:0]  rsp_action,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_reported_len,
   input logic [63:0] rsp_byte_offset,
   input logic [63:0] rsp_xfer_len
);
   import brc_pkg::*;

   // every transaction yields a result through the input and result registers
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_strobe)
      else $error("accepted transaction produced no result");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 2))
      else $error("result without a transaction");

   a_backend_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_action != ACT_NOW)) |-> (rsp_status == ST_OK))
      else $error("backend action with non-ok status");

   a_idle_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && ((rsp_action == ACT_NOW) || (rsp_action == ACT_FLUSH)))
      |-> ((rsp_byte_offset == 64'd0) && (rsp_xfer_len == 64'd0)))
      else $error("offset or length set on a completion");

   a_id_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_action == ACT_ID))
      |-> ((rsp_xfer_len <= 64'(ID_LENGTH)) &&
           (rsp_reported_len == rsp_xfer_len[31:0] + 32'd1)))
      else $error("id copy length wrong");

endmodule

bind block_request_checker brc_checker u_brc_checker (.*);
